@@ hdl/stable_priority_ready_queue_defines.svh @@
// ----------------------------------------------------------------------------
// Stable priority ready queue: assertion macros
// Concurrent assertion helpers, removed when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_READY_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_READY_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define SPRQ_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication.
`define SPRQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SPRQ_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define SPRQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

@@ hdl/sprq_pkg.sv @@
// ----------------------------------------------------------------------------
// sprq_pkg
// Types, codes and sizes shared by the ready queue modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sprq_pkg;

   localparam int MAX_ENTRIES = 32;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

   // command codes (code 3 is unused and ignored)
   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_DUPLICATE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_SHIFT,
      ST_PLACE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]          command;
      logic [7:0]          task_id;
      logic signed [15:0]  task_priority;
   } req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic                head_valid;
      logic [7:0]          head_task;
      logic signed [15:0]  head_priority;
      logic                next_valid;
      logic [7:0]          next_task;
   } rsp_type;

   typedef struct packed {
      logic [7:0]          task_id;
      logic signed [15:0]  prio;
   } entry_type;

   typedef struct packed {
      logic                en;
      logic [IDX_W-1:0]    addr;
      entry_type           data;
   } slot_wr_type;

   typedef struct packed {
      logic                en;
      logic [IDX_W-1:0]    addr;
   } slot_rd_type;

endpackage

`default_nettype wire

@@ hdl/sprq_slot_store.sv @@
// ----------------------------------------------------------------------------
// sprq_slot_store
// Slot memory of the queue with a registered read port and a copy of slot 0.
// ----------------------------------------------------------------------------
`default_nettype none

module sprq_slot_store (
   input  wire logic                  clock,
   input  wire sprq_pkg::slot_wr_type wr,
   input  wire sprq_pkg::slot_rd_type rd,
   output sprq_pkg::entry_type        rd_data,
   output sprq_pkg::entry_type        head
);
   import sprq_pkg::*;

   entry_type slot_mem [MAX_ENTRIES];
   entry_type rd_data_ff;
   entry_type head_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         slot_mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= slot_mem[rd.addr];
      end
   end

   // shadow slot 0 so the head is always at hand
   always_ff @(posedge clock) begin
      if (wr.en && (wr.addr == '0)) begin
         head_ff <= wr.data;
      end
   end

   assign rd_data = rd_data_ff;
   assign head    = head_ff;

endmodule

`default_nettype wire

@@ hdl/stable_priority_ready_queue.sv @@
// ----------------------------------------------------------------------------
// stable_priority_ready_queue
// Bounded task ready queue kept sorted by ascending priority, stable for ties.
// ----------------------------------------------------------------------------
//
//   channel  | prefix | direction | payload
//   ---------+--------+-----------+-----------------------------------------
//   request  | req_   | in        | command, task_id, task_priority
//   response | rsp_   | out       | status, head, successor of queried task
//
// A transaction passes through scan and decide, then shift and place as needed,
// and done to a loaded response; the next request is taken once the sequencer
// is idle again. The scan reads each occupied slot through one registered
// port, and a shift moves one slot per cycle. Reset empties the queue; slots
// are never cleared and only read below the fill count. req_stall is high until
// the sequencer is idle; a done response waits while the last one is stalled.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stable_priority_ready_queue_defines.svh"

module stable_priority_ready_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire sprq_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output sprq_pkg::rsp_type      rsp_data
);
   import sprq_pkg::*;

   // sequencer and counters
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              sh_go_ff, sh_go_in;

   // latched request
   logic [1:0]         cmd_ff, cmd_in;
   logic [7:0]         tid_ff, tid_in;
   logic signed [15:0] prio_ff, prio_in;

   // read pipeline tag
   logic              rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;

   // scan results
   logic              found_ff, found_in;
   logic [IDX_W-1:0]  fpos_ff, fpos_in;
   logic              ins_ff, ins_in;
   logic [CNT_W-1:0]  ipos_ff, ipos_in;
   logic              nxt_vld_ff, nxt_vld_in;
   logic [7:0]        nxt_task_ff, nxt_task_in;
   status_type        status_ff, status_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   slot_wr_type       wr;
   slot_rd_type       rd;
   entry_type         rd_data;
   entry_type         head;

   logic              req_take;
   logic              rsp_free;
   logic              issue;
   logic              task_hit;
   logic              prio_after;
   logic [CNT_W-1:0]  new_count;

   sprq_slot_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd      (rd),
      .rd_data (rd_data),
      .head    (head)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // the one shared compare unit: every slot read passes through it
   assign task_hit   = rd_vld_ff && (rd_data.task_id == tid_ff);
   assign prio_after = rd_vld_ff && (rd_data.prio > prio_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         sh_go_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= rd_vld_in;
         sh_go_ff     <= sh_go_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      cmd_ff      <= cmd_in;
      tid_ff      <= tid_in;
      prio_ff     <= prio_in;
      rd_idx_ff   <= rd_idx_in;
      found_ff    <= found_in;
      fpos_ff     <= fpos_in;
      ins_ff      <= ins_in;
      ipos_ff     <= ipos_in;
      nxt_vld_ff  <= nxt_vld_in;
      nxt_task_ff <= nxt_task_in;
      status_ff   <= status_in;
      rsp_ff      <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      sh_go_in     = sh_go_ff;
      cmd_in       = cmd_ff;
      tid_in       = tid_ff;
      prio_in      = prio_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = rd_idx_ff;
      found_in     = found_ff;
      fpos_in      = fpos_ff;
      ins_in       = ins_ff;
      ipos_in      = ipos_ff;
      nxt_vld_in   = nxt_vld_ff;
      nxt_task_in  = nxt_task_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      issue        = 1'b0;
      new_count    = count_ff;
      wr           = '0;
      rd           = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               // latch the request and arm the scan
               cmd_in     = req_data.command;
               tid_in     = req_data.task_id;
               prio_in    = req_data.task_priority;
               idx_in     = '0;
               found_in   = 1'b0;
               ins_in     = 1'b0;
               ipos_in    = count_ff;
               nxt_vld_in = 1'b0;
               nxt_task_in = '0;
               state_in   = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // issue one read per cycle over the occupied slots
            issue = (idx_ff < count_ff);
            if (issue) begin
               rd.en     = 1'b1;
               rd.addr   = idx_ff[IDX_W-1:0];
               rd_vld_in = 1'b1;
               rd_idx_in = idx_ff[IDX_W-1:0];
               idx_in    = idx_ff + 1'b1;
            end
            // evaluate the slot read last cycle
            if (task_hit) begin
               found_in = 1'b1;
               fpos_in  = rd_idx_ff;
            end
            if (rd_vld_ff && found_ff && (rd_idx_ff == fpos_ff + 1'b1)) begin
               nxt_vld_in  = 1'b1;
               nxt_task_in = rd_data.task_id;
            end
            if (prio_after && !ins_ff) begin
               ins_in  = 1'b1;
               ipos_in = {{(CNT_W-IDX_W){1'b0}}, rd_idx_ff};
            end
            if (!issue && !rd_vld_ff) begin
               state_in = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            status_in = STAT_OK;
            state_in  = ST_DONE;
            case (cmd_ff)
               CMD_INSERT: begin
                  if (found_ff) begin
                     status_in = STAT_DUPLICATE;
                  end else if (count_ff == CNT_W'(MAX_ENTRIES)) begin
                     status_in = STAT_FULL;
                  end else if (ipos_ff == count_ff) begin
                     state_in = ST_PLACE;
                  end else begin
                     // open a gap: move slots up from the tail
                     idx_in   = count_ff - 1'b1;
                     sh_go_in = 1'b1;
                     state_in = ST_SHIFT;
                  end
               end
               CMD_REMOVE: begin
                  if (!found_ff) begin
                     status_in = STAT_NOT_FOUND;
                  end else if (({1'b0, fpos_ff} + 1'b1) < count_ff) begin
                     // close the gap: move slots down toward the position
                     idx_in   = CNT_W'({1'b0, fpos_ff} + 1'b1);
                     sh_go_in = 1'b1;
                     state_in = ST_SHIFT;
                  end
               end
               CMD_QUERY: begin
                  if (!found_ff) begin
                     status_in = STAT_NOT_FOUND;
                  end
               end
               default: begin
                  status_in = STAT_OK;
               end
            endcase
         end

         ST_SHIFT: begin
            issue = sh_go_ff;
            if (issue) begin
               rd.en     = 1'b1;
               rd.addr   = idx_ff[IDX_W-1:0];
               rd_vld_in = 1'b1;
               rd_idx_in = idx_ff[IDX_W-1:0];
               if (cmd_ff == CMD_INSERT) begin
                  if (idx_ff == ipos_ff) begin
                     sh_go_in = 1'b0;
                  end else begin
                     idx_in = idx_ff - 1'b1;
                  end
               end else begin
                  if (idx_ff == count_ff - 1'b1) begin
                     sh_go_in = 1'b0;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
            end
            // write back the slot read last cycle, one place over
            if (rd_vld_ff) begin
               wr.en   = 1'b1;
               wr.data = rd_data;
               if (cmd_ff == CMD_INSERT) begin
                  wr.addr = rd_idx_ff + 1'b1;
               end else begin
                  wr.addr = rd_idx_ff - 1'b1;
               end
            end
            if (!sh_go_ff && !rd_vld_ff) begin
               state_in = (cmd_ff == CMD_INSERT) ? ST_PLACE : ST_DONE;
            end
         end

         ST_PLACE: begin
            wr.en           = 1'b1;
            wr.addr         = ipos_ff[IDX_W-1:0];
            wr.data.task_id = tid_ff;
            wr.data.prio    = prio_ff;
            state_in        = ST_DONE;
         end

         ST_DONE: begin
            // commit the fill count together with the response
            if ((status_ff == STAT_OK) && (cmd_ff == CMD_INSERT)) begin
               new_count = count_ff + 1'b1;
            end else if ((status_ff == STAT_OK) && (cmd_ff == CMD_REMOVE)) begin
               new_count = count_ff - 1'b1;
            end
            if (rsp_free) begin
               count_in             = new_count;
               rsp_valid_in         = 1'b1;
               rsp_in.status        = status_ff;
               rsp_in.head_valid    = (new_count != '0);
               rsp_in.head_task     = (new_count != '0) ? head.task_id : 8'd0;
               rsp_in.head_priority = (new_count != '0) ? head.prio : 16'sd0;
               rsp_in.next_valid    = (cmd_ff == CMD_QUERY) && nxt_vld_ff;
               rsp_in.next_task     = ((cmd_ff == CMD_QUERY) && nxt_vld_ff) ?
                                      nxt_task_ff : 8'd0;
               state_in             = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // fill count never passes the slot count
   `SPRQ_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1,
      count_ff <= CNT_W'(MAX_ENTRIES), "fill count above capacity")

   // a successful insert grows the queue by exactly one task
   `SPRQ_ASSERT_NEXT(a_insert_grows, clock, reset,
      (state_ff == ST_DONE) && rsp_free && (cmd_ff == CMD_INSERT) && (status_ff == STAT_OK),
      count_ff == $past(count_ff) + 1'b1, "insert did not grow the queue")

   // a found task always lies inside the occupied slots
   `SPRQ_ASSERT_IMPLY(a_found_inside, clock, reset, (state_ff == ST_DECIDE) && found_ff,
      ({1'b0, fpos_ff} < count_ff), "found position outside the queue")

   // a response is registered once the sequencer leaves the done state
   `SPRQ_ASSERT_NEXT(a_rsp_loaded, clock, reset, (state_ff == ST_DONE) && rsp_free,
      rsp_valid_ff && (state_ff == ST_IDLE), "response not loaded")

endmodule

`default_nettype wire
